// ===== rtl/core/asfd_pkg.sv =====
// asfd_pkg: shared types and constants of the address string format detector
// holds the character class word, the format codes and the default sizes
// no dependencies

package asfd_pkg;

  // default counter saturation value and queue depth
  localparam int COUNT_MAX_DEF   = 255;
  localparam int QUEUE_DEPTH_DEF = 4;

  // character codes the front looks for
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_BRACKET   = 8'h5B;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  // length and count limits of the rules
  localparam int LEN_BASE85   = 20;
  localparam int LEN_IFINET6  = 32;
  localparam int LEN_IPV4_MIN = 7;
  localparam int LEN_IPV4_MAX = 15;
  localparam int LEN_PREFIX   = 3;
  localparam int DOTS_IPV4    = 3;
  localparam int MAC_LEN_MIN  = 11;
  localparam int MAC_LEN_MAX  = 17;
  localparam int MAC_HEX_MIN  = 6;
  localparam int MAC_HEX_MAX  = 12;
  localparam int MAC_COLONS   = 5;
  localparam int EUI_LEN_MIN  = 15;
  localparam int EUI_LEN_MAX  = 23;
  localparam int EUI_HEX_MIN  = 8;
  localparam int EUI_HEX_MAX  = 16;
  localparam int EUI_COLONS   = 7;

  // format codes of a result word
  typedef enum logic [2:0] {
    FMT_NONE       = 3'd0,
    FMT_BASE85     = 3'd1,
    FMT_IPV4       = 3'd2,
    FMT_BITSTRING  = 3'd3,
    FMT_IFINET6    = 3'd4,
    FMT_MAC        = 3'd5,
    FMT_REVNIBBLES = 3'd6,
    FMT_IPV6       = 3'd7
  } fmt_t;

  // one classified word passed from front to back
  typedef struct packed {
    logic       eos;
    logic       is_dot;
    logic       is_colon;
    logic       is_dec;
    logic       is_hex;
    logic [2:0] lead;   // lead[i]: character equals prefix character i
  } char_class_t;

endpackage

// ===== rtl/core/asfd_front.sv =====
// asfd_front: classifies each incoming character into a class word
// depends on asfd_pkg

module asfd_front
  import asfd_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        end_of_string,
  output logic        q_valid,
  input  logic        q_ready,
  output char_class_t q_data
);

  logic dec;

  // digit classes
  assign dec = (ch >= 8'h30) && (ch <= 8'h39);

  // class word, terminator words carry no dot, colon or digit class; the lead bits still follow ch
  always_comb begin
    q_data.eos      = end_of_string;
    q_data.is_dot   = !end_of_string && (ch == CH_DOT);
    q_data.is_colon = !end_of_string && (ch == CH_COLON);
    q_data.is_dec   = !end_of_string && dec;
    q_data.is_hex   = !end_of_string && (dec || ((ch >= 8'h41) && (ch <= 8'h46)) ||
                                         ((ch >= 8'h61) && (ch <= 8'h66)));
    q_data.lead[0]  = (ch == CH_BACKSLASH);
    q_data.lead[1]  = (ch == CH_BRACKET);
    q_data.lead[2]  = (ch == CH_LOWER_X);
  end

  // handshake passes straight to the queue
  assign q_valid  = in_valid;
  assign in_ready = q_ready;

endmodule

// ===== rtl/core/asfd_queue.sv =====
// asfd_queue: short fifo of class words between front and back
// depends on asfd_pkg

module asfd_queue
  import asfd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  char_class_t wr_data,
  output logic        rd_valid,
  input  logic        rd_ready,
  output char_class_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  char_class_t       mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              push;
  logic              pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/asfd_back.sv =====
// asfd_back: per-string counters, rule evaluation and output register
// depends on asfd_pkg

module asfd_back
  import asfd_pkg::*;
#(
  parameter int COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  char_class_t q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  format_code
);

  localparam int CW = $clog2(COUNT_MAX + 1);
  localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);

  logic [CW-1:0] char_count;
  logic [CW-1:0] dot_count;
  logic [CW-1:0] colon_count;
  logic [CW-1:0] decimal_count;
  logic [CW-1:0] hex_count;
  logic          prefix_match;
  logic          pop;
  logic          lead_ok;
  fmt_t          code_next;
  fmt_t          code;

  // a character word always pops, a terminator needs room at the output
  assign q_ready = !q_data.eos || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // prefix check on the first three characters
  always_comb begin
    lead_ok = 1'b1;
    if (char_count == CW'(0)) begin
      lead_ok = q_data.lead[0];
    end else if (char_count == CW'(1)) begin
      lead_ok = q_data.lead[1];
    end else if (char_count == CW'(2)) begin
      lead_ok = q_data.lead[2];
    end
  end

  // rules in priority order
  always_comb begin
    priority if (char_count == '0) begin
      code_next = FMT_NONE;
    end else if (char_count == CW'(LEN_BASE85) && dot_count == '0 && colon_count == '0) begin
      code_next = FMT_BASE85;
    end else if (char_count >= CW'(LEN_IPV4_MIN) && char_count <= CW'(LEN_IPV4_MAX) &&
                 dot_count == CW'(DOTS_IPV4) && colon_count == '0 &&
                 decimal_count == hex_count) begin
      code_next = FMT_IPV4;
    end else if (char_count >= CW'(LEN_PREFIX) && prefix_match) begin
      code_next = FMT_BITSTRING;
    end else if (char_count == CW'(LEN_IFINET6) && hex_count == CW'(LEN_IFINET6) &&
                 dot_count == '0 && colon_count == '0) begin
      code_next = FMT_IFINET6;
    end else if (char_count >= CW'(MAC_LEN_MIN) && char_count <= CW'(MAC_LEN_MAX) &&
                 hex_count >= CW'(MAC_HEX_MIN) && hex_count <= CW'(MAC_HEX_MAX) &&
                 dot_count == '0 && colon_count == CW'(MAC_COLONS)) begin
      code_next = FMT_MAC;
    end else if (char_count >= CW'(EUI_LEN_MIN) && char_count <= CW'(EUI_LEN_MAX) &&
                 hex_count >= CW'(EUI_HEX_MIN) && hex_count <= CW'(EUI_HEX_MAX) &&
                 dot_count == '0 && colon_count == CW'(EUI_COLONS)) begin
      code_next = FMT_MAC;
    end else if (colon_count == '0 && dot_count != '0) begin
      code_next = FMT_REVNIBBLES;
    end else if (colon_count != '0 && dot_count <= CW'(DOTS_IPV4)) begin
      code_next = FMT_IPV6;
    end else begin
      code_next = FMT_NONE;
    end
  end

  // saturating counters, cleared by a terminator
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count    <= '0;
      dot_count     <= '0;
      colon_count   <= '0;
      decimal_count <= '0;
      hex_count     <= '0;
      prefix_match  <= 1'b1;
    end else if (pop) begin
      if (q_data.eos) begin
        char_count    <= '0;
        dot_count     <= '0;
        colon_count   <= '0;
        decimal_count <= '0;
        hex_count     <= '0;
        prefix_match  <= 1'b1;
      end else begin
        if (!lead_ok) begin
          prefix_match <= 1'b0;
        end
        if (char_count != CMAX) begin
          char_count <= char_count + 1'b1;
        end
        if (q_data.is_dot && dot_count != CMAX) begin
          dot_count <= dot_count + 1'b1;
        end
        if (q_data.is_colon && colon_count != CMAX) begin
          colon_count <= colon_count + 1'b1;
        end
        if (q_data.is_dec && decimal_count != CMAX) begin
          decimal_count <= decimal_count + 1'b1;
        end
        if (q_data.is_hex && hex_count != CMAX) begin
          hex_count <= hex_count + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_data.eos) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.eos) begin
      code <= code_next;
    end
  end

  assign format_code = code;

endmodule

// ===== rtl/core/address_string_format_detect_core.sv =====
// address_string_format_detect_core: top level of the address string format detector
// instantiates asfd_front, asfd_queue and asfd_back; depends on asfd_pkg
//
//   channel   signals                              direction  word
//   input     in_valid in_ready ch end_of_string   in         one character or terminator
//   output    out_valid out_ready format_code      out        one format code per string
//
// one word is accepted per cycle while the queue has room
// a terminator passes through the queue to the output register; the back retires
// one queued word per cycle, a terminator only while the output register has room
// a stalled output blocks a terminator; earlier characters still reach the counters
// synchronous reset empties the queue, clears the counters and drops out_valid

module address_string_format_detect_core
  import asfd_pkg::*;
#(
  parameter int COUNT_MAX   = COUNT_MAX_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] format_code
);

  logic        f_valid;
  logic        f_ready;
  char_class_t f_data;
  logic        b_valid;
  logic        b_ready;
  char_class_t b_data;

  // character classification
  asfd_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .end_of_string (end_of_string),
    .q_valid       (f_valid),
    .q_ready       (f_ready),
    .q_data        (f_data)
  );

  // decoupling queue
  asfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  // counters and rule evaluation
  asfd_back #(
    .COUNT_MAX (COUNT_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (b_valid),
    .q_ready     (b_ready),
    .q_data      (b_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .format_code (format_code)
  );

endmodule

// ===== rtl/core/asfd_checker.sv =====
// asfd_checker: port-level assertions for address_string_format_detect_core
// bound to the top level below; no package dependency

module asfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] format_code
);

  // a stalled result holds its code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(format_code))
    else $error("stalled result word changed or dropped");

  // reset drops any pending result
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word pending after reset");

  // queue is empty and ready right after reset
  assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // a result needs a terminator accepted after reset released
  assert property (@(posedge clk) $rose(out_valid) |-> !$past(rst))
    else $error("result word appeared straight out of reset");

endmodule

bind address_string_format_detect_core asfd_checker u_asfd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .format_code (format_code)
);

// ===== test/tb_address_string_format_detect_core.sv =====
// tb_address_string_format_detect_core: self-checking bench for the address string format detector
// streams directed and random address strings, predicts each format code and checks it
// depends on asfd_pkg and address_string_format_detect_core

module tb_address_string_format_detect_core;
  import asfd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;

  // running counts of the string seen so far
  typedef struct {
    int   chars;
    int   dots;
    int   colons;
    int   decs;
    int   hexes;
    logic prefix_ok;
  } tally_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] format_code;

  tally_t tally;
  fmt_t   expected_codes[$];
  int     error_count = 0;
  int     words_sent = 0;
  int     cycle_count = 0;
  int     sink_hold = 0;
  bit     src_gaps = 1'b0;
  bit     sink_gaps = 1'b0;

  address_string_format_detect_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .ch            (ch),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .format_code   (format_code)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic tally_t tally_clear();
    tally_t t;
    t.chars     = 0;
    t.dots      = 0;
    t.colons    = 0;
    t.decs      = 0;
    t.hexes     = 0;
    t.prefix_ok = 1'b1;
    return t;
  endfunction

  function automatic int bump(input int v);
    return (v >= COUNT_MAX_DEF) ? COUNT_MAX_DEF : v + 1;
  endfunction

  function automatic tally_t tally_char(input tally_t t, input logic [7:0] c);
    logic [7:0] lead [3] = '{CH_BACKSLASH, CH_BRACKET, CH_LOWER_X};
    logic       is_dec;
    logic       is_hex;
    if (t.chars < LEN_PREFIX && c != lead[t.chars])
      t.prefix_ok = 1'b0;
    is_dec = (c >= 8'h30 && c <= 8'h39);
    is_hex = is_dec || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
    t.chars = bump(t.chars);
    if (c == CH_DOT)   t.dots   = bump(t.dots);
    if (c == CH_COLON) t.colons = bump(t.colons);
    if (is_dec)        t.decs   = bump(t.decs);
    if (is_hex)        t.hexes  = bump(t.hexes);
    return t;
  endfunction

  // first matching rule wins
  function automatic fmt_t classify_tally(input tally_t t);
    if (t.chars == 0)
      return FMT_NONE;
    if (t.chars == LEN_BASE85 && t.dots == 0 && t.colons == 0)
      return FMT_BASE85;
    if (t.chars >= LEN_IPV4_MIN && t.chars <= LEN_IPV4_MAX && t.dots == DOTS_IPV4 &&
        t.colons == 0 && t.decs == t.hexes)
      return FMT_IPV4;
    if (t.chars >= LEN_PREFIX && t.prefix_ok)
      return FMT_BITSTRING;
    if (t.chars == LEN_IFINET6 && t.hexes == LEN_IFINET6 && t.dots == 0 && t.colons == 0)
      return FMT_IFINET6;
    if (t.chars >= MAC_LEN_MIN && t.chars <= MAC_LEN_MAX && t.hexes >= MAC_HEX_MIN &&
        t.hexes <= MAC_HEX_MAX && t.dots == 0 && t.colons == MAC_COLONS)
      return FMT_MAC;
    if (t.chars >= EUI_LEN_MIN && t.chars <= EUI_LEN_MAX && t.hexes >= EUI_HEX_MIN &&
        t.hexes <= EUI_HEX_MAX && t.dots == 0 && t.colons == EUI_COLONS)
      return FMT_MAC;
    if (t.colons == 0 && t.dots > 0)
      return FMT_REVNIBBLES;
    if (t.colons != 0 && t.dots <= DOTS_IPV4)
      return FMT_IPV6;
    return FMT_NONE;
  endfunction

  // ---------------------------------------------------------------------------
  // character and string helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_hex_digit();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // biased toward the classes the detector counts and the edges of those classes
  function automatic logic [7:0] rand_addr_char();
    logic [7:0] near [9] = '{8'h2F, 8'h40, 8'h47, 8'h60, 8'h67, 8'h2D, 8'h3B, 8'h7F, 8'h80};
    logic [7:0] lead [3] = '{CH_BACKSLASH, CH_BRACKET, CH_LOWER_X};
    case ($urandom_range(0, 9))
      0:       return CH_DOT;
      1:       return CH_COLON;
      2, 3:    return 8'(8'h30 + $urandom_range(0, 9));
      4:       return 8'(8'h41 + $urandom_range(0, 5));
      5:       return 8'(8'h61 + $urandom_range(0, 5));
      6:       return 8'(8'h67 + $urandom_range(0, 19));
      7:       return 8'($urandom_range(0, 255));
      8:       return near[$urandom_range(0, 8)];
      default: return lead[$urandom_range(0, 2)];
    endcase
  endfunction

  function automatic void push_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++)
      q.push_back(s[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  // send one word, optionally after an idle burst, and update the prediction
  task automatic send_word(input logic [7:0] c, input logic eos);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    ch            <= c;
    end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (eos) begin
      expected_codes.push_back(classify_tally(tally));
      tally = tally_clear();
    end else begin
      tally = tally_char(tally, c);
    end
  endtask

  // characters then a terminator whose character field is random
  task automatic send_chars(input logic [7:0] q[$]);
    foreach (q[i])
      send_word(q[i], 1'b0);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    push_text(q, s);
    send_chars(q);
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    fmt_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_codes.size() == 0) begin
        report_mismatch($sformatf("format code %0d with no string pending", format_code));
      end else begin
        want = expected_codes.pop_front();
        if (format_code !== want)
          report_mismatch($sformatf("format code %0d, expected %0d (%s)",
                                    format_code, want, want.name()));
      end
    end
  end

  // output stall bursts
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
      sink_hold = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codes pending", cycle_count,
               expected_codes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one string per format plus near misses
  task automatic test_each_format();
    send_text("");
    send_text("0123456789abcdefghij");
    send_text("192.168.100.200");
    send_text("1.2.3.4");
    send_text("1.2.3.a4");
    send_text("\\[x0123/12]");
    send_text("\\[");
    send_text("\\[y12");
    send_text("0123456789abcdef0123456789ABCDEF");
    send_text("00:1a:2B:3c:4d:5e");
    send_text("0:1:2:3:4:5");
    send_text("00:11:22:33:44:55:66:77");
    send_text("1.0.0.0.ip6.arpa");
    send_text("fe80::1");
    send_text("::ffff:1.2.3.4");
    send_text("::1.2.3.4.5");
  endtask

  // null, high codes and the edges of the digit ranges
  task automatic test_edge_chars();
    logic [7:0] q[$];
    q = '{8'h00, 8'hFF, CH_COLON, 8'h2F, 8'h40, 8'h47, 8'h60, 8'h67, 8'h80, 8'h7F};
    send_chars(q);
    q = '{8'h00, 8'h00, 8'h00};
    send_chars(q);
    q = '{CH_BACKSLASH, CH_BRACKET, CH_LOWER_X, 8'hFF, 8'h00};
    send_chars(q);
  endtask

  // one past the ceiling; wrapping counters would read as an empty string
  task automatic test_saturation();
    logic [7:0] q[$];
    q.delete();
    repeat (COUNT_MAX_DEF + 1) q.push_back(CH_DOT);
    send_chars(q);
  endtask

  // well-formed addresses with random content, some mutated, plus noise
  task automatic test_random_strings(input int word_budget);
    logic [7:0] q[$];
    logic [7:0] c;
    int         stop_at;
    int         kind;
    int         n;
    int         pos;
    stop_at = words_sent + word_budget;
    while (words_sent < stop_at) begin
      q.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          push_text(q, $sformatf("%0d.%0d.%0d.%0d", $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
        end
        1, 2: begin
          n = (kind == 1) ? MAC_COLONS + 1 : EUI_COLONS + 1;
          for (int i = 0; i < n; i++) begin
            if (i != 0) q.push_back(CH_COLON);
            repeat ($urandom_range(1, 2)) q.push_back(rand_hex_digit());
          end
        end
        3: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            if (i != 0) q.push_back(CH_COLON);
            if ($urandom_range(0, 5) == 0) q.push_back(CH_COLON);
            repeat ($urandom_range(1, 4)) q.push_back(rand_hex_digit());
          end
          if ($urandom_range(0, 3) == 0)
            push_text(q, $sformatf(":%0d.%0d.%0d.%0d", $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
        end
        4: begin
          repeat (LEN_IFINET6) q.push_back(rand_hex_digit());
        end
        5: begin
          repeat (LEN_BASE85) begin
            do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_DOT || c == CH_COLON);
            q.push_back(c);
          end
        end
        6: begin
          q = '{CH_BACKSLASH, CH_BRACKET, CH_LOWER_X};
          repeat ($urandom_range(0, 32)) q.push_back(rand_hex_digit());
          push_text(q, $sformatf("/%0d]", $urandom_range(1, 128)));
        end
        7: begin
          repeat ($urandom_range(1, 32)) begin
            q.push_back(rand_hex_digit());
            q.push_back(CH_DOT);
          end
          if ($urandom_range(0, 1) == 0) push_text(q, "ip6.arpa");
        end
        default: begin
          repeat ($urandom_range(0, 40)) q.push_back(rand_addr_char());
        end
      endcase
      // break one in four: replace, drop or insert a character
      if ($urandom_range(0, 3) == 0 && q.size() > 0) begin
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 2))
          0:       q[pos] = rand_addr_char();
          1:       q.delete(pos);
          default: q.insert(pos, rand_addr_char());
        endcase
      end
      send_chars(q);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    tally = tally_clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    test_each_format();
    test_edge_chars();
    test_saturation();
    test_random_strings(170);

    // closing stretch at full rate
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random_strings(80);
    in_valid <= 1'b0;

    while (expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
